// ===== hw/rtl/mrp_pkg.sv =====
// Shared types, codes and CRC function for the Modbus RTU response parser.
package mrp_pkg;

    // Frame verdict codes
    typedef enum logic [2:0] {
        VERDICT_OK    = 3'd0,
        VERDICT_ADDR  = 3'd1,
        VERDICT_FUNC  = 3'd2,
        VERDICT_CRC   = 3'd3,
        VERDICT_SHORT = 3'd4,
        VERDICT_UNSUP = 3'd5
    } verdict_t;

    // Supported Modbus function codes
    localparam logic [7:0] FUNC_READ_COILS      = 8'h01;
    localparam logic [7:0] FUNC_READ_DISCRETE   = 8'h02;
    localparam logic [7:0] FUNC_READ_HOLDING    = 8'h03;
    localparam logic [7:0] FUNC_READ_INPUT_REGS = 8'h04;
    localparam logic [7:0] FUNC_EXC_STATUS      = 8'h07;

    // Configuration register indexes
    localparam logic CFG_EXPECTED_ADDRESS  = 1'b0;
    localparam logic CFG_EXPECTED_FUNCTION = 1'b1;

    localparam logic [7:0] RESET_EXPECTED_ADDRESS  = 8'h01;
    localparam logic [7:0] RESET_EXPECTED_FUNCTION = 8'h03;

    // CRC-16 constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Byte position saturation point
    localparam logic [8:0] POS_MAX = 9'd511;

    // Work item passed from the classifier to the executor
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        crc_feed;
        logic        emit_elem;
        logic [15:0] elem_value;
        logic [7:0]  elem_index;
        logic        is_end;
        verdict_t    pre_verdict;
        logic        crc_check;
        logic [15:0] received_crc;
        logic [7:0]  element_count;
    } mrp_entry_t;

    // One-byte reflected CRC-16 update, unrolled over eight bit steps
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/mrp_front.sv =====
// Frame classifier: tracks byte position and header, builds one work item per byte.
module mrp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               frame_end,
    output mrp_pkg::mrp_entry_t entry
);
    import mrp_pkg::*;

    logic [7:0]  exp_addr_reg;
    logic [7:0]  exp_func_reg;

    logic [8:0]  pos_reg,      pos_next;
    logic [7:0]  declared_reg, declared_next;
    logic [7:0]  held_reg,     held_next;
    logic [15:0] rcrc_reg,     rcrc_next;
    verdict_t    verdict_reg,  verdict_next;
    logic [7:0]  elems_reg,    elems_next;
    logic [7:0]  func_reg,     func_next;

    logic        is_bits, is_regs, is_stat, supported;
    logic [8:0]  crc_end;
    logic [8:0]  d;
    logic        have_elem;
    logic [15:0] elem_val;
    logic [7:0]  elem_idx;
    logic        crc_feed;
    verdict_t    pre_verdict;
    logic        crc_check;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            exp_addr_reg <= RESET_EXPECTED_ADDRESS;
            exp_func_reg <= RESET_EXPECTED_FUNCTION;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_EXPECTED_ADDRESS:  exp_addr_reg <= cfg_data;
                CFG_EXPECTED_FUNCTION: exp_func_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Decode latched function code; check the incoming byte for a supported code
    always_comb
    begin
        is_bits   = (func_reg == FUNC_READ_COILS) || (func_reg == FUNC_READ_DISCRETE);
        is_regs   = (func_reg == FUNC_READ_HOLDING) || (func_reg == FUNC_READ_INPUT_REGS);
        is_stat   = (func_reg == FUNC_EXC_STATUS);
        supported = (data_byte == FUNC_READ_COILS) || (data_byte == FUNC_READ_DISCRETE)
                 || (data_byte == FUNC_READ_HOLDING) || (data_byte == FUNC_READ_INPUT_REGS)
                 || (data_byte == FUNC_EXC_STATUS);
        crc_end   = is_stat ? 9'd3 : 9'd3 + {1'b0, declared_reg};
        d         = pos_reg - 9'd3;
    end

    // Classify the byte by position and update frame state
    always_comb
    begin
        pos_next      = pos_reg;
        declared_next = declared_reg;
        held_next     = held_reg;
        rcrc_next     = rcrc_reg;
        verdict_next  = verdict_reg;
        elems_next    = elems_reg;
        func_next     = func_reg;
        have_elem     = 1'b0;
        elem_val      = 16'h0000;
        elem_idx      = 8'h00;
        crc_feed      = 1'b0;
        pre_verdict   = VERDICT_OK;
        crc_check     = 1'b0;

        if (pos_reg == 9'd0)
        begin
            crc_feed = 1'b1;
            if (data_byte != exp_addr_reg)
                verdict_next = VERDICT_ADDR;
        end
        else if (pos_reg == 9'd1)
        begin
            crc_feed  = 1'b1;
            func_next = data_byte;
            if (verdict_reg == VERDICT_OK)
            begin
                if (data_byte != exp_func_reg)
                    verdict_next = VERDICT_FUNC;
                else if (!supported)
                    verdict_next = VERDICT_UNSUP;
            end
        end
        else if (verdict_reg == VERDICT_OK)
        begin
            if (pos_reg == 9'd2)
            begin
                crc_feed = 1'b1;
                if (is_stat)
                begin
                    have_elem = 1'b1;
                    elem_val  = {8'h00, data_byte};
                end
                else
                    declared_next = data_byte;
            end
            else if (pos_reg < crc_end)
            begin
                crc_feed = 1'b1;
                if (is_bits)
                begin
                    have_elem = 1'b1;
                    elem_val  = {8'h00, data_byte};
                    elem_idx  = d[7:0];
                end
                else if (is_regs)
                begin
                    if (d[0])
                    begin
                        have_elem = 1'b1;
                        elem_val  = {held_reg, data_byte};
                        elem_idx  = d[8:1];
                    end
                    else
                        held_next = data_byte;
                end
            end
            else if (pos_reg == crc_end)
                rcrc_next = {8'h00, data_byte};
            else if ({1'b0, pos_reg} == {1'b0, crc_end} + 10'd1)
                rcrc_next = {rcrc_reg[15:8] | data_byte, rcrc_reg[7:0]};
        end

        // Advance position, saturating
        pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 9'd1;

        // Settle the verdict except for the CRC compare
        if (pos_next <= 9'd3)
            pre_verdict = VERDICT_ADDR;
        else if (verdict_next != VERDICT_OK)
            pre_verdict = verdict_next;
        else if ({1'b0, pos_next} < ({1'b0, crc_end} + 10'd2))
            pre_verdict = VERDICT_SHORT;
        else
            crc_check = 1'b1;

        if (!frame_end && have_elem)
            elems_next = elems_reg + 8'd1;
    end

    // Build the work item
    always_comb
    begin
        entry.data_byte     = data_byte;
        entry.crc_feed      = crc_feed;
        entry.emit_elem     = have_elem && !frame_end;
        entry.elem_value    = elem_val;
        entry.elem_index    = elem_idx;
        entry.is_end        = frame_end;
        entry.pre_verdict   = pre_verdict;
        entry.crc_check     = crc_check;
        entry.received_crc  = rcrc_next;
        entry.element_count = elems_reg;
    end

    // Update frame state; clear on frame end
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            declared_reg <= '0;
            held_reg     <= '0;
            rcrc_reg     <= '0;
            verdict_reg  <= VERDICT_OK;
            elems_reg    <= '0;
            func_reg     <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                pos_reg      <= '0;
                declared_reg <= '0;
                held_reg     <= '0;
                rcrc_reg     <= '0;
                verdict_reg  <= VERDICT_OK;
                elems_reg    <= '0;
                func_reg     <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                declared_reg <= declared_next;
                held_reg     <= held_next;
                rcrc_reg     <= rcrc_next;
                verdict_reg  <= verdict_next;
                elems_reg    <= elems_next;
                func_reg     <= func_next;
            end
        end
    end

endmodule

// ===== hw/rtl/mrp_queue.sv =====
// Small flip-flop FIFO of work items between classifier and executor.
module mrp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mrp_pkg::mrp_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output mrp_pkg::mrp_entry_t head,
    output logic                empty
);
    import mrp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrp_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers with wrap at depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed item
    always_ff @(posedge clk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/mrp_back.sv =====
// Executor: runs the CRC, settles the verdict and holds the result register.
module mrp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mrp_pkg::mrp_entry_t head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [15:0]         value,
    output logic [7:0]          element_index,
    output logic [2:0]          verdict,
    output logic [7:0]          element_count
);
    import mrp_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_new;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [15:0] value_reg;
    logic [7:0]  elem_idx_reg;
    verdict_t    verdict_reg;
    logic [7:0]  count_reg;
    logic        produces;
    verdict_t    final_verdict;

    assign pop      = !empty && (!out_valid_reg || out_ready);
    assign produces = head.is_end || head.emit_elem;

    // Fold the byte into the CRC and settle the verdict
    always_comb
    begin
        crc_new = head.crc_feed ? crc_update(crc_reg, head.data_byte) : crc_reg;
        if (head.crc_check)
            final_verdict = (head.received_crc != crc_new) ? VERDICT_CRC : VERDICT_OK;
        else
            final_verdict = head.pre_verdict;
    end

    // Next CRC and output valid
    always_comb
    begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (pop)
        begin
            crc_next = head.is_end ? CRC_INIT : crc_new;
            if (produces)
                out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result item
    always_ff @(posedge clk) begin
        if (pop && produces)
        begin
            kind_reg <= head.is_end;
            if (head.is_end)
            begin
                value_reg    <= '0;
                elem_idx_reg <= '0;
                verdict_reg  <= final_verdict;
                count_reg    <= head.element_count;
            end
            else
            begin
                value_reg    <= head.elem_value;
                elem_idx_reg <= head.elem_index;
                verdict_reg  <= VERDICT_OK;
                count_reg    <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign value         = value_reg;
    assign element_index = elem_idx_reg;
    assign verdict       = 3'(verdict_reg);
    assign element_count = count_reg;

endmodule

// ===== hw/rtl/modbus_rtu_response_parser_top.sv =====
// Top level of the Modbus RTU response parser.
//
// Input channel (in_valid/in_ready) takes one frame byte per item, with
// frame_end set on the last byte of the frame. Output channel
// (out_valid/out_ready) delivers data elements (kind 0) as they decode and
// one verdict (kind 1) per frame with the element count.
// One item is accepted per cycle while in_ready is high. A classifier
// registers the frame header state and turns each byte into a work item;
// a queue of QUEUE_DEPTH items feeds an executor that runs the byte-wide
// CRC-16 step and loads the output register. With the queue empty and the
// receiver ready, a result passes the queue and then the output register.
// When the receiver stalls, work items collect in the queue; in_ready drops
// only once the queue is full, and the pending result holds unchanged.
// Reset clears the frame state, empties the queue, drops out_valid and sets
// the expected address to 1 and expected function to 3. Configuration
// writes (cfg_write_en, cfg_index, cfg_data) take effect at the next edge.
module modbus_rtu_response_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [15:0] value,
    output logic [7:0]  element_index,
    output logic [2:0]  verdict,
    output logic [7:0]  element_count
);
    import mrp_pkg::*;

    mrp_entry_t push_entry;
    mrp_entry_t head_entry;
    logic       q_full, q_empty, q_pop;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify incoming bytes
    mrp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .data_byte    (data_byte),
        .frame_end    (frame_end),
        .entry        (push_entry)
    );

    // Buffer work items
    mrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head_entry),
        .empty     (q_empty)
    );

    // Execute and deliver results
    mrp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_entry),
        .empty         (q_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .value         (value),
        .element_index (element_index),
        .verdict       (verdict),
        .element_count (element_count)
    );

endmodule
